[design/bitmap_block_allocator_assert.svh]
// Assertion macros used by the checker file of the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`endif

[design/bba_pkg.sv]
// Shared constants of the bitmap block allocator: defaults, field widths and codes.
`default_nettype none

package bba_pkg;

    // Defaults of the top-level parameters.
    localparam int BLOCK_COUNT_DEF   = 1024;
    localparam int MAP_WORD_BITS_DEF = 32;

    // Fixed field widths of the command and result beats.
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

`default_nettype wire

[design/bitmap_block_allocator.sv]
// Top level of the first-fit bitmap block allocator.
`default_nettype none

// First-fit block allocator over a used/free bitmap held in one synchronous RAM.
// A command beat is taken at a rising edge with start high and busy low; every
// command returns exactly one result beat, shown for one cycle with
// o_result_strobe high, and the receiver cannot stall it. An allocate command
// reads the bitmap one word per cycle from word 0 upward and keeps busy high
// while it examines the words; the result appears in the cycle after the last
// word is examined and a new command can be taken in that same cycle. The
// single RAM read port and its registered read set that pace. A free command
// steps through S_DIV1 and S_DIV2, which split the index into word and bit
// with a reciprocal multiply and one correction step, and then S_FCHK, which
// checks and clears the bit after the RAM read; its result shows in the cycle
// after S_FCHK. A free command whose index is at or above BLOCK_COUNT never
// goes busy and reports its error in the next cycle. After reset the block
// runs a clearing pass that writes every bitmap word to zero, one word per
// cycle, holding busy high meanwhile.

module bitmap_block_allocator #(
    parameter int BLOCK_COUNT   = bba_pkg::BLOCK_COUNT_DEF,
    parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [bba_pkg::IDX_W-1:0]     i_block_index,
    output logic                          o_result_strobe,
    output logic [bba_pkg::STATUS_W-1:0]  o_status,
    output logic [bba_pkg::IDX_W-1:0]     o_granted_block
);

    localparam int IDX_W     = bba_pkg::IDX_W;
    localparam int MAP_WORDS = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int LAST_BITS = BLOCK_COUNT - (MAP_WORDS - 1) * MAP_WORD_BITS;
    localparam int BASE_RAW  = $clog2(BLOCK_COUNT + MAP_WORD_BITS);
    localparam int BASE_W    = (BASE_RAW > IDX_W) ? BASE_RAW : IDX_W;

    // Reciprocal of the word width; the estimate floor(idx * RECIP / 2^SHIFT)
    // is the true quotient or one below it for any 10-bit index.
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = IDX_W + RECIP_SHIFT;
    localparam int RECIP       = (1 << RECIP_SHIFT) / MAP_WORD_BITS;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV1  = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;

    // Bitmap RAM, one bit per block, 1 means used.
    logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] r_rdata;

    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;

    logic [2:0]               r_state, n_state;
    logic [ADDR_W-1:0]        r_clr, n_clr;
    logic [ADDR_W-1:0]        r_ckw, n_ckw;
    logic [BASE_W-1:0]        r_base, n_base;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_q, n_q;
    logic [BIT_W-1:0]         r_bitpos, n_bitpos;
    logic [ADDR_W-1:0]        r_waddr, n_waddr;
    logic                     r_res_stb, n_res_stb;
    logic [bba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]         r_grant, n_grant;

    logic                     find_found;
    logic [BIT_W-1:0]         find_pos;
    logic [MAP_WORD_BITS-1:0] find_marked;

    logic [PROD_W-1:0]        prod;
    logic [IDX_W:0]           rem_raw;
    logic [IDX_W:0]           rem_fix;
    logic [IDX_W-1:0]         q_fix;
    logic [BASE_W-1:0]        grant_sum;
    logic                     accept;
    logic                     idx_in_range;

    bba_first_free #(
        .WORD_BITS (MAP_WORD_BITS),
        .LAST_BITS (LAST_BITS)
    ) u_find (
        .i_word   (r_rdata),
        .i_last   (r_ckw == LAST_ADDR),
        .o_found  (find_found),
        .o_pos    (find_pos),
        .o_marked (find_marked)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Any index that lands inside the map words but past the last block is
    // also at or above BLOCK_COUNT, so one compare covers both error cases.
    assign idx_in_range = (int'(i_block_index) < BLOCK_COUNT);

    // Quotient estimate and remainder of the free index by the word width.
    assign prod      = PROD_W'(r_idx) * PROD_W'(RECIP);
    assign rem_raw   = {1'b0, r_idx} - (IDX_W + 1)'(r_q * MAP_WORD_BITS);
    assign grant_sum = r_base + BASE_W'(find_pos);

    always_comb begin
        if (rem_raw >= (IDX_W + 1)'(MAP_WORD_BITS)) begin
            q_fix   = r_q + IDX_W'(1);
            rem_fix = rem_raw - (IDX_W + 1)'(MAP_WORD_BITS);
        end else begin
            q_fix   = r_q;
            rem_fix = rem_raw;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_ckw     = r_ckw;
        n_base    = r_base;
        n_idx     = r_idx;
        n_q       = r_q;
        n_bitpos  = r_bitpos;
        n_waddr   = r_waddr;
        n_res_stb = 1'b0;
        n_status  = r_status;
        n_grant   = r_grant;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = r_waddr;
        wr_data   = '0;

        case (r_state)
            S_CLEAR: begin
                // Sweep zeros through the bitmap after reset.
                wr_en   = 1'b1;
                wr_addr = r_clr;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_op == bba_pkg::OP_ALLOC) begin
                        // Fetch word 0 now; it is examined next cycle.
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_ckw   = '0;
                        n_base  = '0;
                        n_state = S_SCAN;
                    end else if (idx_in_range) begin
                        n_idx   = i_block_index;
                        n_state = S_DIV1;
                    end else begin
                        n_res_stb = 1'b1;
                        n_status  = bba_pkg::ST_BAD;
                        n_grant   = '0;
                    end
                end
            end
            S_SCAN: begin
                // r_rdata holds word r_ckw; the next word is fetched in the
                // same cycle so the scan keeps one word per cycle.
                if (find_found) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_ckw;
                    wr_data   = find_marked;
                    n_res_stb = 1'b1;
                    n_status  = bba_pkg::ST_OK;
                    n_grant   = grant_sum[IDX_W-1:0];
                    n_state   = S_IDLE;
                end else if (r_ckw == LAST_ADDR) begin
                    n_res_stb = 1'b1;
                    n_status  = bba_pkg::ST_FULL;
                    n_grant   = '0;
                    n_state   = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ckw + ADDR_W'(1);
                    n_ckw   = r_ckw + ADDR_W'(1);
                    n_base  = r_base + BASE_W'(MAP_WORD_BITS);
                end
            end
            S_DIV1: begin
                n_q     = prod[RECIP_SHIFT +: IDX_W];
                n_state = S_DIV2;
            end
            S_DIV2: begin
                // Corrected word and bit of the block; fetch its word.
                rd_en    = 1'b1;
                rd_addr  = ADDR_W'(q_fix);
                n_waddr  = ADDR_W'(q_fix);
                n_bitpos = BIT_W'(rem_fix);
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                n_res_stb = 1'b1;
                n_state   = S_IDLE;
                if (r_rdata[r_bitpos]) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_waddr;
                    wr_data  = r_rdata & ~(MAP_WORD_BITS'(1) << r_bitpos);
                    n_status = bba_pkg::ST_OK;
                    n_grant  = r_idx;
                end else begin
                    // Double free: the map is left as it is.
                    n_status = bba_pkg::ST_BAD;
                    n_grant  = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Bitmap RAM: one write and one registered read per cycle. Commands run
    // one at a time, so a write always lands before the next read of that word.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_res_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_res_stb <= n_res_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ckw    <= n_ckw;
        r_base   <= n_base;
        r_idx    <= n_idx;
        r_q      <= n_q;
        r_bitpos <= n_bitpos;
        r_waddr  <= n_waddr;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    assign o_result_strobe = r_res_stb;
    assign o_status        = r_status;
    assign o_granted_block = r_grant;

endmodule

`default_nettype wire

[design/bba_first_free.sv]
// Lowest-free-bit finder for one bitmap word, with masking of the padding bits.
`default_nettype none

module bba_first_free #(
    parameter int WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF,
    parameter int LAST_BITS = bba_pkg::MAP_WORD_BITS_DEF,
    localparam int BIT_W = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_last,
    output logic                 o_found,
    output logic [BIT_W-1:0]     o_pos,
    output logic [WORD_BITS-1:0] o_marked
);

    logic [WORD_BITS-1:0] w_eff;
    logic [WORD_BITS-1:0] onehot;

    // Bits past the last block of the final word count as used.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            w_eff[i] = i_word[i] | (i_last && (i >= LAST_BITS));
        end
    end

    // Isolate the lowest clear bit with one add.
    assign onehot   = ~w_eff & (w_eff + WORD_BITS'(1));
    assign o_found  = ~&w_eff;
    assign o_marked = i_word | onehot;

    always_comb begin
        o_pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (onehot[i]) begin
                o_pos = o_pos | BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[design/bba_checker.sv]
// Port-level checker of the bitmap block allocator and its bind to the top level.
`default_nettype none

`include "bitmap_block_allocator_assert.svh"

module bba_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_result_strobe,
    input wire logic [bba_pkg::STATUS_W-1:0] o_status,
    input wire logic [bba_pkg::IDX_W-1:0]    o_granted_block
);

    // An accepted beat either starts work or answers in the very next cycle.
    `BBA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_result_strobe)

    // A result beat only follows a cycle of work or an accepted command.
    `BBA_ASSERT_NOW(a_result_has_cause, o_result_strobe, $past(busy) || $past(start))

    // Failed requests report block zero.
    `BBA_ASSERT_NOW(a_error_zero_index, o_result_strobe && (o_status != bba_pkg::ST_OK),
                    o_granted_block == '0)

    // Only the three defined status codes are ever reported.
    `BBA_ASSERT_NOW(a_status_defined, o_result_strobe,
                    (o_status == bba_pkg::ST_OK) || (o_status == bba_pkg::ST_FULL) ||
                    (o_status == bba_pkg::ST_BAD))

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_status        (o_status),
    .o_granted_block (o_granted_block)
);

`default_nettype wire
